// ===== hw/rtl/crd_pkg.sv =====
// Shared types, constants and single-precision helper functions for the ray direction block.
`timescale 1ns / 1ps

package crd_pkg;

   typedef logic [31:0] fp32_type;

   typedef struct packed {
      logic [23:0]        man;
      logic signed [9:0]  ex;
   } fp_unpack_type;

   localparam fp32_type FP_QNAN    = 32'h7FC0_0000;
   localparam fp32_type FP_ONE     = 32'h3F80_0000;
   localparam fp32_type FP_TWO     = 32'h4000_0000;
   localparam fp32_type FP_NEG_ONE = 32'hBF80_0000;

   localparam int CSR_COUNT = 6;
   localparam int CSR_IDX_W = $clog2(CSR_COUNT);

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_COLS01 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_COLS01 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_COLS01 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_COLS01 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS01_COL3 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS23_COL3 = CSR_IDX_W'(5);

   localparam logic [63:0] CSR_RESET [CSR_COUNT] = '{
      64'h0000_0000_3F80_0000,
      64'h3F80_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h3F80_0000_0000_0000
   };

   localparam int DIV_STEPS  = 27;
   localparam int SQRT_STEPS = 26;
   localparam int DIV_LAT    = DIV_STEPS + 2;
   localparam int SQRT_LAT   = SQRT_STEPS + 2;
   localparam int FRONT_LAT  = 5;
   localparam int DOT_LAT    = 3;
   localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT + DOT_LAT + SQRT_LAT + DIV_LAT + 1;
   localparam int TAIL_LAT   = SQRT_LAT + DIV_LAT;

   function automatic logic signed [11:0] sx12(logic signed [9:0] v);
      return {{2{v[9]}}, v};
   endfunction

   function automatic logic fp_is_nan(fp32_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(fp32_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic fp_is_zero(fp32_type a);
      return a[30:0] == 31'd0;
   endfunction

   // Returns a nonzero finite value as a 24-bit mantissa with its leading one at bit 23.
   function automatic fp_unpack_type fp_unpack(fp32_type a);
      fp_unpack_type u;
      logic [23:0]   m;
      logic [4:0]    lz;
      lz = 5'd0;
      if (a[30:23] == 8'd0) begin
         m = {1'b0, a[22:0]};
         for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
               lz = 5'(23 - i);
            end
         end
         u.man = m << lz;
         u.ex  = -10'sd126 - $signed({5'd0, lz});
      end else begin
         u.man = {1'b1, a[22:0]};
         u.ex  = $signed({2'b00, a[30:23]}) - 10'sd127;
      end
      return u;
   endfunction

   // Rounds man * 2^ex to nearest even; man has its leading one at bit 47 or 46.
   function automatic fp32_type fp_round(logic sgn, logic signed [11:0] ex,
                                         logic [47:0] man, logic sticky);
      logic [47:0]        m;
      logic [47:0]        ms;
      logic signed [11:0] e;
      logic signed [11:0] be;
      logic signed [11:0] d;
      logic [5:0]         sh;
      logic               st;
      logic               g;
      logic               lsb;
      logic               up;
      logic [30:0]        mag;
      m  = man;
      e  = ex;
      st = sticky;
      if (!m[47]) begin
         m = m << 1;
         e = e - 12'sd1;
      end
      be = e + 12'sd174;
      if (be >= 12'sd255) begin
         return {sgn, 8'hFF, 23'd0};
      end
      if (be >= 12'sd1) begin
         g   = m[23];
         st  = st | (|m[22:0]);
         lsb = m[24];
         mag = {be[7:0], m[46:24]};
      end else begin
         d   = 12'sd1 - be;
         sh  = (d > 12'sd26) ? 6'd26 : d[5:0];
         ms  = m >> sh;
         st  = st | ((ms << sh) != m);
         g   = ms[23];
         st  = st | (|ms[22:0]);
         lsb = ms[24];
         mag = {8'd0, ms[46:24]};
      end
      up = g & (st | lsb);
      return {sgn, mag + 31'(up)};
   endfunction

   function automatic fp32_type fp_mul(fp32_type a, fp32_type b);
      fp_unpack_type ua;
      fp_unpack_type ub;
      logic [47:0]   p;
      logic          s;
      s = a[31] ^ b[31];
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return FP_QNAN;
      end
      if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
         return FP_QNAN;
      end
      if (fp_is_inf(a) || fp_is_inf(b)) begin
         return {s, 8'hFF, 23'd0};
      end
      if (fp_is_zero(a) || fp_is_zero(b)) begin
         return {s, 31'd0};
      end
      ua = fp_unpack(a);
      ub = fp_unpack(b);
      p  = ua.man * ub.man;
      return fp_round(s, sx12(ua.ex) + sx12(ub.ex) - 12'sd46, p, 1'b0);
   endfunction

   function automatic fp32_type fp_add(fp32_type a, fp32_type b);
      fp_unpack_type      ua;
      fp_unpack_type      ub;
      fp_unpack_type      big;
      fp_unpack_type      sml;
      logic               swap;
      logic               sgn;
      logic signed [9:0]  d;
      logic [52:0]        x;
      logic [52:0]        y;
      logic [52:0]        y0;
      logic [52:0]        r;
      logic [5:0]         p;
      logic [5:0]         sh;
      logic [47:0]        m;
      logic               st;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return FP_QNAN;
      end
      if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
         return FP_QNAN;
      end
      if (fp_is_inf(a)) begin
         return a;
      end
      if (fp_is_inf(b)) begin
         return b;
      end
      if (fp_is_zero(a) && fp_is_zero(b)) begin
         return {a[31] & b[31], 31'd0};
      end
      if (fp_is_zero(a)) begin
         return b;
      end
      if (fp_is_zero(b)) begin
         return a;
      end
      ua   = fp_unpack(a);
      ub   = fp_unpack(b);
      swap = (ub.ex > ua.ex) || ((ub.ex == ua.ex) && (ub.man > ua.man));
      big  = swap ? ub : ua;
      sml  = swap ? ua : ub;
      sgn  = swap ? b[31] : a[31];
      d    = big.ex - sml.ex;
      x    = {1'b0, big.man, 28'd0};
      y0   = {1'b0, sml.man, 28'd0};
      if (d > 10'sd28) begin
         y = 53'd1;
      end else begin
         y = y0 >> d[4:0];
      end
      r = (a[31] ^ b[31]) ? (x - y) : (x + y);
      if (r == 53'd0) begin
         return 32'd0;
      end
      p = 6'd0;
      for (int i = 0; i < 53; i++) begin
         if (r[i]) begin
            p = 6'(i);
         end
      end
      if (p >= 6'd47) begin
         sh = p - 6'd47;
         m  = 48'(r >> sh);
         st = ((r >> sh) << sh) != r;
      end else begin
         sh = 6'd47 - p;
         m  = 48'(r) << sh;
         st = 1'b0;
      end
      return fp_round(sgn, sx12(big.ex) + $signed({6'd0, p}) - 12'sd98, m, st);
   endfunction

endpackage

// ===== hw/rtl/crd_fdiv.sv =====
// Pipelined single-precision divider, one quotient bit per stage.
`timescale 1ns / 1ps

module crd_fdiv (
   input  logic              clock,
   input  logic              adv,
   input  crd_pkg::fp32_type num,
   input  crd_pkg::fp32_type den,
   output crd_pkg::fp32_type quo
);
   import crd_pkg::*;

   typedef struct packed {
      logic               spec;
      fp32_type           spec_val;
      logic               sgn;
      logic signed [11:0] ex;
      logic [23:0]        dv;
   } div_ctl_type;

   div_ctl_type        ctl_ff [DIV_STEPS+1];
   logic [24:0]        rem_ff [DIV_STEPS+1];
   logic [26:0]        q_ff   [DIV_STEPS+1];
   fp32_type           quo_ff;

   div_ctl_type        ctl_in;
   fp_unpack_type      un;
   fp_unpack_type      ud;
   logic [24:0]        rem_in [DIV_STEPS+1];
   logic [26:0]        q_in   [DIV_STEPS+1];

   always_comb begin
      un = fp_unpack(num);
      ud = fp_unpack(den);
      ctl_in.sgn      = num[31] ^ den[31];
      ctl_in.ex       = sx12(un.ex) - sx12(ud.ex) - 12'sd47;
      ctl_in.dv       = ud.man;
      ctl_in.spec     = 1'b1;
      ctl_in.spec_val = FP_QNAN;
      if (fp_is_zero(den)) begin
         if (!(fp_is_nan(num) || fp_is_zero(num))) begin
            ctl_in.spec_val = {num[31] ^ den[31], 8'hFF, 23'd0};
         end
      end else if (fp_is_nan(num) || fp_is_nan(den)) begin
         ctl_in.spec_val = FP_QNAN;
      end else if (fp_is_inf(num) && fp_is_inf(den)) begin
         ctl_in.spec_val = FP_QNAN;
      end else if (fp_is_inf(num)) begin
         ctl_in.spec_val = {num[31] ^ den[31], 8'hFF, 23'd0};
      end else if (fp_is_inf(den) || fp_is_zero(num)) begin
         ctl_in.spec_val = {num[31] ^ den[31], 31'd0};
      end else begin
         ctl_in.spec = 1'b0;
      end
   end

   always_comb begin
      logic [24:0] diff;
      rem_in[0] = {1'b0, un.man};
      q_in[0]   = 27'd0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         diff = rem_ff[k-1] - {1'b0, ctl_ff[k-1].dv};
         if (rem_ff[k-1] >= {1'b0, ctl_ff[k-1].dv}) begin
            rem_in[k] = {diff[23:0], 1'b0};
            q_in[k]   = {q_ff[k-1][25:0], 1'b1};
         end else begin
            rem_in[k] = {rem_ff[k-1][23:0], 1'b0};
            q_in[k]   = {q_ff[k-1][25:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         if (ctl_ff[DIV_STEPS].spec) begin
            quo_ff <= ctl_ff[DIV_STEPS].spec_val;
         end else begin
            quo_ff <= fp_round(ctl_ff[DIV_STEPS].sgn, ctl_ff[DIV_STEPS].ex,
                               {q_ff[DIV_STEPS], 21'd0}, rem_ff[DIV_STEPS] != 25'd0);
         end
      end
   end

   assign quo = quo_ff;

endmodule

// ===== hw/rtl/crd_fsqrt.sv =====
// Pipelined single-precision square root, one root bit per stage.
`timescale 1ns / 1ps

module crd_fsqrt (
   input  logic              clock,
   input  logic              adv,
   input  crd_pkg::fp32_type rad,
   output crd_pkg::fp32_type root
);
   import crd_pkg::*;

   typedef struct packed {
      logic               spec;
      fp32_type           spec_val;
      logic signed [11:0] ex;
   } sqrt_ctl_type;

   sqrt_ctl_type  ctl_ff  [SQRT_STEPS+1];
   logic [51:0]   bits_ff [SQRT_STEPS+1];
   logic [27:0]   rem_ff  [SQRT_STEPS+1];
   logic [25:0]   q_ff    [SQRT_STEPS+1];
   fp32_type      root_ff;

   sqrt_ctl_type  ctl_in;
   fp_unpack_type ur;
   logic [24:0]   m25;
   logic signed [11:0] k;
   logic [51:0]   bits_in [SQRT_STEPS+1];
   logic [27:0]   rem_in  [SQRT_STEPS+1];
   logic [25:0]   q_in    [SQRT_STEPS+1];

   always_comb begin
      ur = fp_unpack(rad);
      k  = sx12(ur.ex) - 12'sd23;
      if (k[0]) begin
         m25 = {ur.man, 1'b0};
         k   = k - 12'sd1;
      end else begin
         m25 = {1'b0, ur.man};
      end
      ctl_in.ex       = ((k - 12'sd26) >>> 1) - 12'sd22;
      ctl_in.spec     = 1'b1;
      ctl_in.spec_val = FP_QNAN;
      if (rad[30:23] == 8'hFF) begin
         if (!(fp_is_nan(rad) || rad[31])) begin
            ctl_in.spec_val = rad;
         end
      end else if (fp_is_zero(rad)) begin
         ctl_in.spec_val = rad;
      end else if (rad[31]) begin
         ctl_in.spec_val = FP_QNAN;
      end else begin
         ctl_in.spec = 1'b0;
      end
   end

   always_comb begin
      logic [27:0] cur;
      logic [27:0] trial;
      bits_in[0] = {1'b0, m25, 26'd0};
      rem_in[0]  = 28'd0;
      q_in[0]    = 26'd0;
      for (int s = 1; s <= SQRT_STEPS; s++) begin
         cur          = {rem_ff[s-1][25:0], bits_ff[s-1][51:50]};
         trial        = {q_ff[s-1], 2'b01};
         bits_in[s]   = {bits_ff[s-1][49:0], 2'b00};
         if (cur >= trial) begin
            rem_in[s] = cur - trial;
            q_in[s]   = {q_ff[s-1][24:0], 1'b1};
         end else begin
            rem_in[s] = cur;
            q_in[s]   = {q_ff[s-1][24:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 0; s <= SQRT_STEPS; s++) begin
            bits_ff[s] <= bits_in[s];
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
         end
         for (int s = 1; s <= SQRT_STEPS; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         if (ctl_ff[SQRT_STEPS].spec) begin
            root_ff <= ctl_ff[SQRT_STEPS].spec_val;
         end else begin
            root_ff <= fp_round(1'b0, ctl_ff[SQRT_STEPS].ex, {q_ff[SQRT_STEPS], 22'd0},
                                rem_ff[SQRT_STEPS] != 28'd0);
         end
      end
   end

   assign root = root_ff;

endmodule

// ===== hw/rtl/camera_ray_direction.sv =====
// Top level of the camera ray direction pipeline.
`timescale 1ns / 1ps

// Each transaction carries a screen point (x, y) as IEEE single bits and yields one unit ray
// direction through the configured inverse view-projection matrix, in single precision with
// round to nearest even and every NaN returned as 7FC00000. The pipeline takes a new
// transaction every cycle and returns results in order; most of its stages belong to
// the bit-per-stage divider, used once for the perspective divide and once for 1/sqrt, and the
// square root unit. When a result is held by rsp_ready low, the whole pipeline holds.
// Matrix registers may be written only while no transaction is in flight.
module camera_ray_direction (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_screen_x,
   input  logic [31:0]                     req_screen_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_dir_x,
   output logic [31:0]                     rsp_dir_y,
   output logic [31:0]                     rsp_dir_z,
   input  logic                            csr_we,
   input  logic [crd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_wdata
);
   import crd_pkg::*;

   logic [63:0]           csr_ff [CSR_COUNT];
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;

   fp32_type dbl_x_ff, dbl_y_ff;
   fp32_type px_ff, py_ff;
   fp32_type t0_ff [4];
   fp32_type t1_ff [4];
   fp32_type sum_ff [4];
   fp32_type vec_ff [4];
   fp32_type m0 [4];
   fp32_type m1 [4];
   fp32_type m3 [4];
   fp32_type q [3];
   fp32_type q6_ff [3];
   fp32_type sq_ff [3];
   fp32_type q7_ff [3];
   fp32_type sxy_ff, zz_ff;
   fp32_type q8_ff [3];
   fp32_type dot_ff;
   fp32_type root;
   fp32_type inv;
   fp32_type dly_ff [TAIL_LAT][3];
   fp32_type dir_ff [3];

   assign adv       = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         for (int i = 0; i < CSR_COUNT; i++) begin
            csr_ff[i] <= CSR_RESET[i];
         end
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         end
         if (csr_we && (csr_index < CSR_IDX_W'(CSR_COUNT))) begin
            csr_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_comb begin
      m0[0] = csr_ff[CSR_ROW0_COLS01][31:0];
      m1[0] = csr_ff[CSR_ROW0_COLS01][63:32];
      m0[1] = csr_ff[CSR_ROW1_COLS01][31:0];
      m1[1] = csr_ff[CSR_ROW1_COLS01][63:32];
      m0[2] = csr_ff[CSR_ROW2_COLS01][31:0];
      m1[2] = csr_ff[CSR_ROW2_COLS01][63:32];
      m0[3] = csr_ff[CSR_ROW3_COLS01][31:0];
      m1[3] = csr_ff[CSR_ROW3_COLS01][63:32];
      m3[0] = csr_ff[CSR_ROWS01_COL3][31:0];
      m3[1] = csr_ff[CSR_ROWS01_COL3][63:32];
      m3[2] = csr_ff[CSR_ROWS23_COL3][31:0];
      m3[3] = csr_ff[CSR_ROWS23_COL3][63:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dbl_x_ff <= fp_mul(req_screen_x, FP_TWO);
         dbl_y_ff <= fp_mul(req_screen_y, FP_TWO);
         px_ff    <= fp_add(dbl_x_ff, FP_NEG_ONE);
         py_ff    <= fp_add(dbl_y_ff, FP_NEG_ONE);
         for (int r = 0; r < 4; r++) begin
            t0_ff[r]  <= fp_mul(m0[r], px_ff);
            t1_ff[r]  <= fp_mul(m1[r], py_ff);
            sum_ff[r] <= fp_add(t0_ff[r], t1_ff[r]);
            vec_ff[r] <= fp_add(sum_ff[r], m3[r]);
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_persp
      crd_fdiv u_div (
         .clock (clock),
         .adv   (adv),
         .num   (vec_ff[c]),
         .den   (vec_ff[3]),
         .quo   (q[c])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            q6_ff[c] <= q[c];
            sq_ff[c] <= fp_mul(q[c], q[c]);
            q7_ff[c] <= q6_ff[c];
            q8_ff[c] <= q7_ff[c];
         end
         sxy_ff <= fp_add(sq_ff[0], sq_ff[1]);
         zz_ff  <= sq_ff[2];
         dot_ff <= fp_add(sxy_ff, zz_ff);
      end
   end

   crd_fsqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .rad   (dot_ff),
      .root  (root)
   );

   crd_fdiv u_recip (
      .clock (clock),
      .adv   (adv),
      .num   (FP_ONE),
      .den   (root),
      .quo   (inv)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            dly_ff[0][c] <= q8_ff[c];
            for (int i = 1; i < TAIL_LAT; i++) begin
               dly_ff[i][c] <= dly_ff[i-1][c];
            end
            dir_ff[c] <= fp_mul(dly_ff[TAIL_LAT-1][c], inv);
         end
      end
   end

   assign rsp_dir_x = dir_ff[0];
   assign rsp_dir_y = dir_ff[1];
   assign rsp_dir_z = dir_ff[2];

endmodule

// ===== sim/tb_camera_ray_direction.sv =====
// Self-checking testbench for the camera ray direction pipeline.
`timescale 1ns / 1ps

module tb_camera_ray_direction;
   import crd_pkg::*;

   typedef struct {
      fp32_type x;
      fp32_type y;
      fp32_type z;
   } ray_dir_type;

   typedef struct {
      fp32_type    sx;
      fp32_type    sy;
      logic        known;
      ray_dir_type dir;
   } screen_row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = PIPE_DEPTH + 10;
   localparam int PHASE_ITEMS    = 185;
   localparam int PHASE_COUNT    = 10;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [31:0]          req_screen_x;
   logic [31:0]          req_screen_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [31:0]          rsp_dir_x;
   logic [31:0]          rsp_dir_y;
   logic [31:0]          rsp_dir_z;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;

   logic [63:0]  matrix [CSR_COUNT];
   ray_dir_type  dir_queue [$];
   int           mismatch_count;
   int           idle_cycles;
   logic         hold_request;

   camera_ray_direction u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_screen_x (req_screen_x),
      .req_screen_y (req_screen_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_dir_x    (rsp_dir_x),
      .rsp_dir_y    (rsp_dir_y),
      .rsp_dir_z    (rsp_dir_z),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic is_nan32(fp32_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf32(fp32_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero32(fp32_type a);
      return a[30:0] == 31'd0;
   endfunction

   function automatic real widen(fp32_type a);
      real r;
      if (a[30:23] == 8'd0) begin
         r = $itor(a[22:0]) * (2.0 ** -149);
         return a[31] ? -r : r;
      end
      return $bitstoreal({a[31], 11'(a[30:23] - 8'd127 + 11'd1023 - 11'd0), a[22:0], 29'd0});
   endfunction

   // Narrows a nonzero double to single precision with round to nearest even.
   function automatic fp32_type narrow(real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      logic [31:0] mag;
      d = $realtobits(r);
      e = int'(d[62:52]) - 1023;
      m = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) begin
         sh = 60;
      end
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if ((rem > half) || ((rem == half) && q[0])) begin
         q = q + 64'd1;
      end
      if (e < -126) begin
         return {d[63], q[30:0]};
      end
      if (e + 127 >= 255) begin
         return {d[63], 8'hFF, 23'd0};
      end
      mag = (32'(e + 127) << 23) + 32'(q) - 32'h0080_0000;
      if (mag >= 32'h7F80_0000) begin
         return {d[63], 8'hFF, 23'd0};
      end
      return {d[63], mag[30:0]};
   endfunction

   function automatic fp32_type sp_mul(fp32_type a, fp32_type b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan32(a) || is_nan32(b)) begin
         return FP_QNAN;
      end
      if ((is_inf32(a) && is_zero32(b)) || (is_zero32(a) && is_inf32(b))) begin
         return FP_QNAN;
      end
      if (is_inf32(a) || is_inf32(b)) begin
         return {s, 8'hFF, 23'd0};
      end
      if (is_zero32(a) || is_zero32(b)) begin
         return {s, 31'd0};
      end
      return narrow(widen(a) * widen(b));
   endfunction

   function automatic fp32_type sp_add(fp32_type a, fp32_type b);
      real r;
      if (is_nan32(a) || is_nan32(b)) begin
         return FP_QNAN;
      end
      if (is_inf32(a) && is_inf32(b) && (a[31] != b[31])) begin
         return FP_QNAN;
      end
      if (is_inf32(a)) begin
         return a;
      end
      if (is_inf32(b)) begin
         return b;
      end
      if (is_zero32(a) && is_zero32(b)) begin
         return {a[31] & b[31], 31'd0};
      end
      if (is_zero32(a)) begin
         return b;
      end
      if (is_zero32(b)) begin
         return a;
      end
      r = widen(a) + widen(b);
      if (r == 0.0) begin
         return 32'd0;
      end
      return narrow(r);
   endfunction

   function automatic fp32_type sp_div(fp32_type a, fp32_type b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan32(a) || is_nan32(b)) begin
         return FP_QNAN;
      end
      if (is_zero32(b)) begin
         return is_zero32(a) ? FP_QNAN : {s, 8'hFF, 23'd0};
      end
      if (is_inf32(a) && is_inf32(b)) begin
         return FP_QNAN;
      end
      if (is_inf32(a)) begin
         return {s, 8'hFF, 23'd0};
      end
      if (is_inf32(b) || is_zero32(a)) begin
         return {s, 31'd0};
      end
      return narrow(widen(a) / widen(b));
   endfunction

   function automatic fp32_type sp_sqrt(fp32_type a);
      if (is_nan32(a) || (a[31] && !is_zero32(a))) begin
         return FP_QNAN;
      end
      if (is_zero32(a) || is_inf32(a)) begin
         return a;
      end
      return narrow($sqrt(widen(a)));
   endfunction

   function automatic fp32_type canon(fp32_type a);
      return is_nan32(a) ? FP_QNAN : a;
   endfunction

   function automatic ray_dir_type trace_ray(fp32_type sx, fp32_type sy);
      fp32_type    px;
      fp32_type    py;
      fp32_type    v [4];
      fp32_type    col3 [4];
      fp32_type    x;
      fp32_type    y;
      fp32_type    z;
      fp32_type    dot;
      fp32_type    inv;
      ray_dir_type d;
      px = sp_add(sp_mul(FP_TWO, sx), FP_NEG_ONE);
      py = sp_add(sp_mul(FP_TWO, sy), FP_NEG_ONE);
      col3[0] = matrix[CSR_ROWS01_COL3][31:0];
      col3[1] = matrix[CSR_ROWS01_COL3][63:32];
      col3[2] = matrix[CSR_ROWS23_COL3][31:0];
      col3[3] = matrix[CSR_ROWS23_COL3][63:32];
      for (int r = 0; r < 4; r++) begin
         v[r] = sp_add(sp_add(sp_mul(matrix[r][31:0], px), sp_mul(matrix[r][63:32], py)),
                       col3[r]);
      end
      x = sp_div(v[0], v[3]);
      y = sp_div(v[1], v[3]);
      z = sp_div(v[2], v[3]);
      dot = sp_add(sp_add(sp_mul(x, x), sp_mul(y, y)), sp_mul(z, z));
      inv = sp_div(FP_ONE, sp_sqrt(dot));
      d.x = canon(sp_mul(x, inv));
      d.y = canon(sp_mul(y, inv));
      d.z = canon(sp_mul(z, inv));
      return d;
   endfunction

   function automatic fp32_type random_coord();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'h0000_0000;
               1: return FP_ONE;
               2: return 32'h3F00_0000;
               3: return 32'h7F80_0000;
               4: return 32'h8000_0000;
               default: return 32'h7F7F_FFFF;
            endcase
         end
         default: return {1'b0, 8'($urandom_range(110, 126)), 23'($urandom)};
      endcase
   endfunction

   function automatic fp32_type random_entry(int kind);
      case (kind)
         0: return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
         1: return $urandom;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return {1'($urandom), 31'h7F7F_FFFF};
         5: return {1'($urandom), 8'd0, 23'($urandom)};
         default: return ($urandom_range(0, 3) == 0) ? 32'd0 :
                         {1'($urandom), 8'($urandom_range(120, 132)), 23'($urandom)};
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      matrix[idx] = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_point(fp32_type sx, fp32_type sy, logic known, ray_dir_type dir);
      ray_dir_type d;
      req_valid    = 1'b1;
      req_screen_x = sx;
      req_screen_y = sy;
      do @(posedge clock); while (!req_ready);
      d = trace_ray(sx, sy);
      dir_queue.push_back(known ? dir : d);
      if (known && ((d.x != dir.x) || (d.y != dir.y) || (d.z != dir.z))) begin
         $display("Predictor disagrees with typed result for %h %h", sx, sy);
         mismatch_count++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (dir_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_points(int count);
      int          left;
      int          burst;
      ray_dir_type none;
      none = '{default: '0};
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_point(random_coord(), random_coord(), 1'b0, none);
            left--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   screen_row_type directed [] = '{
      '{32'h3F80_0000, 32'h3F00_0000, 1'b1, '{FP_ONE, 32'd0, 32'd0}},
      '{32'h3F00_0000, 32'h3F00_0000, 1'b1, '{FP_QNAN, FP_QNAN, FP_QNAN}},
      '{32'h7FC0_0000, 32'h3F00_0000, 1'b1, '{FP_QNAN, FP_QNAN, FP_QNAN}},
      '{32'h3F00_0000, 32'h0000_0000, 1'b1, '{32'd0, 32'hBF80_0000, 32'd0}},
      '{32'h0000_0000, 32'h0000_0000, 1'b0, '{default: '0}},
      '{32'h3F80_0000, 32'h3F80_0000, 1'b0, '{default: '0}},
      '{32'h0000_0000, 32'h3F80_0000, 1'b0, '{default: '0}},
      '{32'h7F80_0000, 32'h3F00_0000, 1'b0, '{default: '0}},
      '{32'hFF80_0000, 32'h0000_0000, 1'b0, '{default: '0}},
      '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, '{default: '0}},
      '{32'h0000_0001, 32'h8000_0000, 1'b0, '{default: '0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{default: '0}},
      '{32'hBF80_0000, 32'h4000_0000, 1'b0, '{default: '0}},
      '{32'h3F40_0000, 32'h3E80_0000, 1'b0, '{default: '0}},
      '{32'h3F00_0001, 32'h3EFF_FFFF, 1'b0, '{default: '0}}
   };

   always @(posedge clock) begin
      ray_dir_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dir_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected transaction: %h %h %h", rsp_dir_x, rsp_dir_y, rsp_dir_z);
            end
         end else begin
            e = dir_queue.pop_front();
            if (rsp_dir_x !== e.x || rsp_dir_y !== e.y || rsp_dir_z !== e.z) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected %h %h %h, got %h %h %h",
                           e.x, e.y, e.z, rsp_dir_x, rsp_dir_y, rsp_dir_z);
               end
            end
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            case ($urandom_range(0, 3))
               0: rsp_ready = 1'b1;
               1: rsp_ready = $urandom_range(0, 3) != 0;
               2: rsp_ready = $urandom_range(0, 1);
               default: rsp_ready = ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_screen_x   = '0;
      req_screen_y   = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      mismatch_count = 0;
      hold_request   = 1'b0;
      for (int i = 0; i < CSR_COUNT; i++) begin
         matrix[i] = CSR_RESET[i];
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_point(directed[i].sx, directed[i].sy, directed[i].known, directed[i].dir);
      end
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         kind = (p < 7) ? p : $urandom_range(0, 6);
         for (int r = 0; r < CSR_COUNT; r++) begin
            write_reg(CSR_IDX_W'(r), {random_entry(kind), random_entry(kind)});
         end
         if (p == 0) begin
            write_reg(CSR_ROWS23_COL3, {FP_ONE, random_entry(kind)});
         end
         if (p == 3) begin
            hold_request = 1'b1;
         end
         send_random_points(PHASE_ITEMS);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
